/* rtl/core/wrapped_axis_distance_interpolate_core_assert.svh */
// Assertion macros for the checker file of this block.
// Each macro samples on the rising edge of clk and is switched off while rst_n is low.
`ifndef WRAPPED_AXIS_DISTANCE_INTERPOLATE_CORE_ASSERT_SVH
`define WRAPPED_AXIS_DISTANCE_INTERPOLATE_CORE_ASSERT_SVH

// Same-cycle implication.
`define WADI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WADI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/wadi_pkg.sv */
`timescale 1ns / 1ps

package wadi_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_DIST   = 2'd1,
    FUNC_EQUAL  = 2'd2,
    FUNC_INTERP = 2'd3
  } wadi_func_t;

  typedef enum logic [1:0] {
    KIND_COORD = 2'd0,
    KIND_DIST  = 2'd1,
    KIND_EQUAL = 2'd2
  } wadi_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_FOLD,
    ST_MULT,
    ST_FIN,
    ST_CORR,
    ST_ROOT,
    ST_EMIT
  } wadi_state_t;

  // Configuration register indexes.
  localparam logic CFG_WRAP_MASK = 1'b0;
  localparam logic CFG_EQUAL_TOL = 1'b1;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;
  localparam int VALUE_W     = 32;
  localparam int FRAC_W      = 17;
  localparam int TOL_W       = 16;
  localparam int MASK_W      = 8;
  localparam int AXIS_W      = 3;
  localparam int SUM_W       = 64;
  localparam int ROOT_W      = 32;

  // Working width for spans and differences, wide enough for a fold.
  localparam int WIDE_W = 36;

  // Interpolation parameter t equal to one in Q1.16.
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

endpackage

/* rtl/core/wadi_ram.sv */
`timescale 1ns / 1ps

module wadi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/wadi_isqrt.sv */
`timescale 1ns / 1ps

// Restoring integer square root, one result bit per cycle.
module wadi_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wadi_pkg::SUM_W-1:0]   radicand,
  output logic                         busy,
  output logic [wadi_pkg::ROOT_W-1:0]  root
);

  localparam int RW = wadi_pkg::ROOT_W + 1;
  localparam int CW = $clog2(wadi_pkg::ROOT_W);

  logic                         busy_r, busy_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [wadi_pkg::ROOT_W-1:0]  root_r, root_nxt;
  logic [wadi_pkg::SUM_W-1:0]   x_r, x_nxt;
  logic [RW+1:0]                rem_sh;
  logic [RW+1:0]                trial;
  logic [RW+1:0]                rem_sub;
  logic                         ge;

  assign rem_sh  = {rem_r, x_r[wadi_pkg::SUM_W-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign rem_sub = rem_sh - trial;
  assign ge      = (rem_sh >= trial);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    x_nxt    = x_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      rem_nxt  = '0;
      root_nxt = '0;
      x_nxt    = radicand;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
      root_nxt = {root_r[wadi_pkg::ROOT_W-2:0], ge};
      x_nxt    = {x_r[wadi_pkg::SUM_W-3:0], 2'b00};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    x_r    <= x_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

/* rtl/core/wrapped_axis_distance_interpolate_core.sv */
// Per-axis metric unit for state vectors whose axes may wrap around. Every input beat carries
// one axis: a load beat (tuser 0) stores that axis's low and high bound, and distance (1),
// equality (2) and interpolate (3) beats stream the axes of a vector with tlast on the final
// one. Bounds of an axis must be loaded before the axis is used. Distance folds each wrapped
// difference by the axis span, sums the squares with saturation and gives the integer square
// root on the last axis; equality gives its flag on the last axis; interpolate gives one
// coordinate per beat, going the short way round wrapped axes. The unit works on one beat at a
// time through a small sequencer around one shared multiplier. A load is stored as accepted.
// Equality passes difference, fold and finish states, plus emit on the last axis. Distance adds
// multiply, and on the last axis a bit-serial square root giving one result bit per cycle, then
// emit. Interpolate passes difference, fold, multiply, finish, correction and emit. A finished
// result sits in the output register while the next beat is already being worked on.
// Configuration writes are taken at any time and should only be made while the unit is idle.
`timescale 1ns / 1ps

module wrapped_axis_distance_interpolate_core #(
  parameter int AXES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // Bits from lowest: axis[2:0], value_a[34:3], value_b[66:35], fraction[83:67], zero pad.
  input  logic [87:0] in_tdata,
  // Bits from lowest: func[1:0].
  input  logic [1:0]  in_tuser,
  // Marks the last axis of a vector.
  input  logic        in_tlast,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // Bits from lowest: coordinate[31:0], distance_out[63:32], equal_flag[64], zero pad.
  output logic [71:0] out_tdata,
  // Bits from lowest: result_kind[1:0].
  output logic [1:0]  out_tuser,
  // Configuration writes: index 0 is wrap_mask, index 1 is equal_tolerance.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int WW = wadi_pkg::WIDE_W;
  localparam int VW = wadi_pkg::VALUE_W;
  localparam int RW = 38;
  localparam int PW = 56;
  localparam logic signed [RW-1:0] R_MAX = 38'sd2147483647;
  localparam logic signed [RW-1:0] R_MIN = -38'sd2147483648;
  localparam logic signed [PW-1:0] HALF  = 56'sd32768;

  // Input beat fields.
  logic [wadi_pkg::AXIS_W-1:0] in_axis;
  logic signed [VW-1:0]        in_value_a;
  logic signed [VW-1:0]        in_value_b;
  logic [wadi_pkg::FRAC_W-1:0] in_fraction;
  wadi_pkg::wadi_func_t        in_func;
  logic                        in_acc;
  logic                        in_inrange;

  assign in_axis     = in_tdata[2:0];
  assign in_value_a  = in_tdata[34:3];
  assign in_value_b  = in_tdata[66:35];
  assign in_fraction = in_tdata[83:67];
  assign in_func     = wadi_pkg::wadi_func_t'(in_tuser);
  assign in_acc      = in_tvalid & in_tready;
  assign in_inrange  = (32'(in_axis) < AXES);

  // Configuration registers.
  logic [wadi_pkg::MASK_W-1:0] wrap_mask_r, wrap_mask_nxt;
  logic [wadi_pkg::TOL_W-1:0]  tol_r, tol_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    wrap_mask_nxt = wrap_mask_r;
    tol_nxt       = tol_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wadi_pkg::CFG_WRAP_MASK: wrap_mask_nxt = cfg_data[wadi_pkg::MASK_W-1:0];
        wadi_pkg::CFG_EQUAL_TOL: tol_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  wadi_pkg::wadi_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic out_load;
  logic ram_we;
  logic sq_start;
  logic sq_busy;

  // Item registers, held for the whole item.
  wadi_pkg::wadi_func_t        func_r;
  logic signed [VW-1:0]        a_r;
  logic signed [VW-1:0]        b_r;
  logic [wadi_pkg::FRAC_W-1:0] t_r;
  logic                        last_r;
  logic                        inrange_r;
  logic                        wraps_r;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wadi_pkg::ST_IDLE: begin
        if (in_acc && (in_func != wadi_pkg::FUNC_LOAD)) begin
          state_nxt = wadi_pkg::ST_DIFF;
        end
      end
      wadi_pkg::ST_DIFF: state_nxt = wadi_pkg::ST_FOLD;
      wadi_pkg::ST_FOLD: begin
        state_nxt = (func_r == wadi_pkg::FUNC_EQUAL) ? wadi_pkg::ST_FIN : wadi_pkg::ST_MULT;
      end
      wadi_pkg::ST_MULT: state_nxt = wadi_pkg::ST_FIN;
      wadi_pkg::ST_FIN: begin
        case (func_r)
          wadi_pkg::FUNC_DIST:   state_nxt = last_r ? wadi_pkg::ST_ROOT : wadi_pkg::ST_IDLE;
          wadi_pkg::FUNC_EQUAL:  state_nxt = last_r ? wadi_pkg::ST_EMIT : wadi_pkg::ST_IDLE;
          wadi_pkg::FUNC_INTERP: state_nxt = wadi_pkg::ST_CORR;
          default:               state_nxt = wadi_pkg::ST_IDLE;
        endcase
      end
      wadi_pkg::ST_CORR: state_nxt = wadi_pkg::ST_EMIT;
      wadi_pkg::ST_ROOT: begin
        if (!sq_busy) begin
          state_nxt = wadi_pkg::ST_EMIT;
        end
      end
      wadi_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = wadi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wadi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == wadi_pkg::ST_IDLE);
    ram_we    = in_acc && (in_func == wadi_pkg::FUNC_LOAD) && in_inrange;
    sq_start  = (state_r == wadi_pkg::ST_FIN) && (func_r == wadi_pkg::FUNC_DIST) && last_r;
    out_load  = (state_r == wadi_pkg::ST_EMIT) && out_free;
  end

  // Bounds table: low bound in the lower half, high bound in the upper half. The read is
  // issued at the accepting edge, so the data is there in the first working cycle.
  logic [AW-1:0]     ram_addr;
  logic [2*VW-1:0]   bnd_rdata;

  assign ram_addr = AW'(in_axis);

  wadi_ram #(
    .WIDTH (2 * VW),
    .DEPTH (AXES)
  ) u_bounds (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata ({in_value_b, in_value_a}),
    .raddr (ram_addr),
    .rdata (bnd_rdata)
  );

  // First working cycle: span and raw difference. An axis past the table reads zero bounds.
  logic signed [VW-1:0] lo_w, hi_w;
  logic signed [VW-1:0] lo_r, hi_r;
  logic signed [WW-1:0] diam_nxt, diff_nxt;
  logic signed [WW-1:0] diam_r, diff_r;

  assign lo_w     = inrange_r ? $signed(bnd_rdata[VW-1:0]) : '0;
  assign hi_w     = inrange_r ? $signed(bnd_rdata[2*VW-1:VW]) : '0;
  assign diam_nxt = WW'(hi_w) - WW'(lo_w);
  assign diff_nxt = (func_r == wadi_pkg::FUNC_INTERP) ? (WW'(b_r) - WW'(a_r))
                                                      : (WW'(a_r) - WW'(b_r));

  // Second working cycle: fold on wrapped axes and set up the multiplier. The folded value
  // keeps its sign for interpolation; distance needs only its magnitude.
  logic signed [WW-1:0] twod;
  logic                 up_nxt, dn_nxt;
  logic                 up_r, dn_r;
  logic signed [WW-1:0] fold_d;
  logic signed [WW-1:0] fold_mag;
  logic                 sat_nxt, sat_r;
  logic signed [WW-1:0] op_a_nxt, op_a_r;
  logic signed [VW:0]   op_b_nxt, op_b_r;
  logic signed [WW-1:0] tol_w;
  logic signed [WW-1:0] abs_diff;
  logic signed [WW-1:0] wrap_gap;
  logic signed [WW-1:0] abs_gap;
  logic                 ne_nxt, ne_r;

  assign twod     = diff_r <<< 1;
  assign up_nxt   = wraps_r && (twod > diam_r);
  assign dn_nxt   = wraps_r && !up_nxt && ((-twod) > diam_r);
  assign fold_d   = up_nxt ? (diff_r - diam_r) : (dn_nxt ? (diff_r + diam_r) : diff_r);
  assign fold_mag = fold_d[WW-1] ? -fold_d : fold_d;
  assign sat_nxt  = |fold_mag[WW-1:VW];
  assign op_a_nxt = (func_r == wadi_pkg::FUNC_DIST) ? fold_mag : fold_d;
  assign op_b_nxt = (func_r == wadi_pkg::FUNC_DIST) ? $signed({1'b0, fold_mag[VW-1:0]})
                                                    : $signed({16'd0, t_r});

  // An axis differs when the gap exceeds the tolerance, unless it wraps and the gap is close
  // to a whole span.
  assign tol_w    = $signed({20'd0, tol_r});
  assign abs_diff = diff_r[WW-1] ? -diff_r : diff_r;
  assign wrap_gap = abs_diff - diam_r;
  assign abs_gap  = wrap_gap[WW-1] ? -wrap_gap : wrap_gap;
  assign ne_nxt   = (abs_diff > tol_w) && (!wraps_r || (abs_gap > tol_w));

  // Shared multiplier: the square of a magnitude, or a signed folded difference times t.
  logic signed [WW+VW:0] prod_full;
  logic [wadi_pkg::SUM_W-1:0] prod_r;

  assign prod_full = op_a_r * op_b_r;

  // Finishing cycle: accumulate, update the running flag, or round the interpolation.
  logic [wadi_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                       still_r, still_nxt;
  logic [wadi_pkg::SUM_W-1:0] sq;
  logic [wadi_pkg::SUM_W:0]   sum_wide;
  logic [wadi_pkg::SUM_W-1:0] sum_sat;
  logic                       still_upd;
  logic                       eq_res_r;
  logic signed [PW-1:0]       a_sh;
  logic signed [PW-1:0]       prod_s;
  logic signed [PW-1:0]       r_sum;
  logic signed [RW-1:0]       r_r;

  assign sq        = sat_r ? '1 : prod_r;
  assign sum_wide  = {1'b0, sum_r} + {1'b0, sq};
  assign sum_sat   = sum_wide[wadi_pkg::SUM_W] ? '1 : sum_wide[wadi_pkg::SUM_W-1:0];
  assign still_upd = still_r && !ne_r;

  // Round half up: floor((a * 65536 + d * t + 32768) / 65536).
  assign a_sh   = $signed({{8{a_r[VW-1]}}, a_r, 16'd0});
  assign prod_s = PW'($signed(prod_r));
  assign r_sum  = a_sh + prod_s + HALF;

  always_comb begin
    sum_nxt   = sum_r;
    still_nxt = still_r;
    if (state_r == wadi_pkg::ST_FIN) begin
      if (func_r == wadi_pkg::FUNC_DIST) begin
        sum_nxt = last_r ? '0 : sum_sat;
      end
      if (func_r == wadi_pkg::FUNC_EQUAL) begin
        still_nxt = last_r ? 1'b1 : still_upd;
      end
    end
  end

  // Correction cycle: bring a folded result back into the axis range, then clamp to 32 bits.
  logic signed [RW-1:0] lo38, hi38, diam38;
  logic signed [RW-1:0] r_corr;
  logic signed [VW-1:0] coord_nxt, coord_res_r;

  assign lo38   = RW'(lo_r);
  assign hi38   = RW'(hi_r);
  assign diam38 = RW'(diam_r);

  always_comb begin
    r_corr = r_r;
    if (up_r && (r_r < lo38)) begin
      r_corr = r_r + diam38;
    end else if (dn_r && (r_r > hi38)) begin
      r_corr = r_r - diam38;
    end
    if (r_corr > R_MAX) begin
      coord_nxt = R_MAX[VW-1:0];
    end else if (r_corr < R_MIN) begin
      coord_nxt = R_MIN[VW-1:0];
    end else begin
      coord_nxt = r_corr[VW-1:0];
    end
  end

  // Square root of the saturated sum on the last distance beat.
  logic [wadi_pkg::ROOT_W-1:0] root;

  wadi_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_sat),
    .busy     (sq_busy),
    .root     (root)
  );

  // Output register.
  wadi_pkg::wadi_kind_t kind_w;
  wadi_pkg::wadi_kind_t out_kind_r;
  logic [VW-1:0]        out_coord_r;
  logic [VW-1:0]        out_dist_r;
  logic                 out_eq_r;

  always_comb begin
    case (func_r)
      wadi_pkg::FUNC_DIST:  kind_w = wadi_pkg::KIND_DIST;
      wadi_pkg::FUNC_EQUAL: kind_w = wadi_pkg::KIND_EQUAL;
      default:              kind_w = wadi_pkg::KIND_COORD;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wadi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      still_r     <= 1'b1;
      wrap_mask_r <= '0;
      tol_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      still_r     <= still_nxt;
      wrap_mask_r <= wrap_mask_nxt;
      tol_r       <= tol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_func;
      a_r       <= in_value_a;
      b_r       <= in_value_b;
      t_r       <= (in_fraction > wadi_pkg::FRAC_ONE) ? wadi_pkg::FRAC_ONE : in_fraction;
      last_r    <= in_tlast;
      inrange_r <= in_inrange;
      wraps_r   <= in_inrange && wrap_mask_r[in_axis];
    end
    if (state_r == wadi_pkg::ST_DIFF) begin
      lo_r   <= lo_w;
      hi_r   <= hi_w;
      diam_r <= diam_nxt;
      diff_r <= diff_nxt;
    end
    if (state_r == wadi_pkg::ST_FOLD) begin
      up_r   <= up_nxt;
      dn_r   <= dn_nxt;
      sat_r  <= sat_nxt;
      op_a_r <= op_a_nxt;
      op_b_r <= op_b_nxt;
      ne_r   <= ne_nxt;
    end
    if (state_r == wadi_pkg::ST_MULT) begin
      prod_r <= prod_full[wadi_pkg::SUM_W-1:0];
    end
    if (state_r == wadi_pkg::ST_FIN) begin
      r_r      <= r_sum[RW+15:16];
      eq_res_r <= still_upd;
    end
    if (state_r == wadi_pkg::ST_CORR) begin
      coord_res_r <= coord_nxt;
    end
    if (out_load) begin
      out_kind_r  <= kind_w;
      out_coord_r <= (kind_w == wadi_pkg::KIND_COORD) ? coord_res_r : '0;
      out_dist_r  <= (kind_w == wadi_pkg::KIND_DIST) ? root : '0;
      out_eq_r    <= (kind_w == wadi_pkg::KIND_EQUAL) ? eq_res_r : 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_eq_r, out_dist_r, out_coord_r};
  assign out_tuser  = out_kind_r;

endmodule

/* rtl/core/wadi_checker.sv */
`timescale 1ns / 1ps
`include "wrapped_axis_distance_interpolate_core_assert.svh"

module wadi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A coordinate beat carries no distance and no flag.
  `WADI_ASSERT_IMP(a_coord_clean, out_tvalid && (out_tuser == wadi_pkg::KIND_COORD), out_tdata[64:32] == 33'd0, "coordinate beat with stray fields")

  // A distance beat carries no coordinate and no flag.
  `WADI_ASSERT_IMP(a_dist_clean, out_tvalid && (out_tuser == wadi_pkg::KIND_DIST), (out_tdata[31:0] == 32'd0) && !out_tdata[64], "distance beat with stray fields")

  // An equality beat carries only the flag.
  `WADI_ASSERT_IMP(a_equal_clean, out_tvalid && (out_tuser == wadi_pkg::KIND_EQUAL), out_tdata[63:0] == 64'd0, "equality beat with stray fields")

  // A working beat keeps the input closed for at least the next cycle.
  `WADI_ASSERT_NXT(a_busy_after_item, in_tvalid && in_tready && (in_tuser != wadi_pkg::FUNC_LOAD), !in_tready, "input open right after a working beat")

  // A stalled result holds.
  `WADI_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind wrapped_axis_distance_interpolate_core wadi_checker u_wadi_checker (.*);

/* verif/wrapped_axis_distance_interpolate_core_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the wrapped-axis metric unit. A scoreboard object keeps its own
// copy of the bounds table, the running sum of squares and the running equality flag, and
// predicts every result beat as input beats are accepted. Plain tasks drive the input and
// configuration channels. A separate process drives out_tready and checks each result.
module wrapped_axis_distance_interpolate_core_test;

  localparam int CLK_HALF_NS     = 2;
  localparam int RESET_CYCLES    = 8;
  // No beat on any channel for this many cycles means the unit is hung.
  localparam int STALL_LIMIT     = 4000;
  // The slowest beat is the last distance axis; this covers any work in flight.
  localparam int SETTLE_CYCLES   = 60;
  localparam int PRESSURE_CYCLES = 400;
  localparam int PHASES          = 6;
  localparam int BEATS_PER_PHASE = 300;
  localparam longint Q_MAX       = 64'sd2147483647;
  localparam longint Q_MIN       = -64'sd2147483648;

  typedef struct {
    wadi_pkg::wadi_func_t                func;
    logic [wadi_pkg::AXIS_W-1:0]         axis;
    logic signed [wadi_pkg::VALUE_W-1:0] a;
    logic signed [wadi_pkg::VALUE_W-1:0] b;
    logic [wadi_pkg::FRAC_W-1:0]         frac;
    logic                                last;
  } axis_beat_t;

  typedef struct {
    wadi_pkg::wadi_kind_t         kind;
    logic [wadi_pkg::VALUE_W-1:0] coord;
    logic [wadi_pkg::ROOT_W-1:0]  distance;
    logic                         flag;
  } metric_result_t;

  class metric_scoreboard;
    longint                       axis_low[8];
    longint                       axis_high[8];
    logic [wadi_pkg::MASK_W-1:0]  wrap_mask;
    longint                       tolerance;
    logic [wadi_pkg::SUM_W-1:0]   square_sum;
    logic                         still_equal;
    metric_result_t               pending_results[$];
    int                           mismatches;
    int                           coords_seen;
    int                           dists_seen;
    int                           flags_seen;

    function new();
      foreach (axis_low[i]) begin
        axis_low[i]  = 0;
        axis_high[i] = 0;
      end
      wrap_mask   = '0;
      tolerance   = 0;
      square_sum  = '0;
      still_equal = 1'b1;
      mismatches  = 0;
      coords_seen = 0;
      dists_seen  = 0;
      flags_seen  = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == wadi_pkg::CFG_WRAP_MASK) begin
        wrap_mask = data[wadi_pkg::MASK_W-1:0];
      end else begin
        tolerance = longint'(data);
      end
    endfunction

    // Rounded d * t / 2^16 with ties going up; the arithmetic shift floors.
    function longint lerp_step(longint d, longint t);
      return (d * t + 32768) >>> 16;
    endfunction

    function logic [wadi_pkg::ROOT_W-1:0] root_of(logic [wadi_pkg::SUM_W-1:0] v);
      logic [wadi_pkg::ROOT_W-1:0] r;
      logic [wadi_pkg::ROOT_W-1:0] c;
      r = '0;
      for (int i = wadi_pkg::ROOT_W - 1; i >= 0; i--) begin
        c = r | (32'd1 << i);
        if (64'(c) * 64'(c) <= v) r = c;
      end
      return r;
    endfunction

    function longint mag_of(longint x);
      return (x < 0) ? -x : x;
    endfunction

    function void take_input(axis_beat_t beat);
      longint a, b, t, lo, hi, span, diff, ad, r;
      logic wraps;
      logic [wadi_pkg::SUM_W-1:0] sq;
      logic [wadi_pkg::SUM_W:0] total;
      metric_result_t res;
      logic emits;
      a     = beat.a;
      b     = beat.b;
      t     = (beat.frac > wadi_pkg::FRAC_ONE) ? 65536 : longint'(beat.frac);
      lo    = axis_low[beat.axis];
      hi    = axis_high[beat.axis];
      span  = hi - lo;
      wraps = wrap_mask[beat.axis];
      res.kind     = wadi_pkg::KIND_COORD;
      res.coord    = '0;
      res.distance = '0;
      res.flag     = 1'b0;
      emits = 1'b0;
      case (beat.func)
        wadi_pkg::FUNC_LOAD: begin
          axis_low[beat.axis]  = a;
          axis_high[beat.axis] = b;
        end
        wadi_pkg::FUNC_DIST: begin
          diff = a - b;
          if (wraps) begin
            if (2 * diff > span) diff = span - diff;
            else if (-2 * diff > span) diff = span + diff;
          end
          ad = mag_of(diff);
          sq = (ad >= 64'sh1_0000_0000) ? '1 : 64'(ad) * 64'(ad);
          total = {1'b0, square_sum} + {1'b0, sq};
          square_sum = total[wadi_pkg::SUM_W] ? '1 : total[wadi_pkg::SUM_W-1:0];
          if (beat.last) begin
            res.kind     = wadi_pkg::KIND_DIST;
            res.distance = root_of(square_sum);
            square_sum   = '0;
            emits = 1'b1;
          end
        end
        wadi_pkg::FUNC_EQUAL: begin
          ad = mag_of(a - b);
          if (ad > tolerance && (!wraps || mag_of(ad - span) > tolerance)) still_equal = 1'b0;
          if (beat.last) begin
            res.kind = wadi_pkg::KIND_EQUAL;
            res.flag = still_equal;
            still_equal = 1'b1;
            emits = 1'b1;
          end
        end
        default: begin
          diff = b - a;
          if (wraps && 2 * diff > span) begin
            r = a + lerp_step(b - span - a, t);
            if (r < lo) r += span;
          end else if (wraps && -2 * diff > span) begin
            r = a + lerp_step(b + span - a, t);
            if (r > hi) r -= span;
          end else begin
            r = a + lerp_step(diff, t);
          end
          if (r > Q_MAX) r = Q_MAX;
          if (r < Q_MIN) r = Q_MIN;
          res.coord = r[wadi_pkg::VALUE_W-1:0];
          emits = 1'b1;
        end
      endcase
      if (emits) pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_output(logic [wadi_pkg::OUT_TDATA_W-1:0] data, logic [1:0] user);
      metric_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing predicted: expected none, %s %0d tdata %h",
                 $time, "actual tuser", user, data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      case (user)
        wadi_pkg::KIND_COORD: coords_seen++;
        wadi_pkg::KIND_DIST:  dists_seen++;
        default:              flags_seen++;
      endcase
      if (user !== want.kind) begin
        $display("%0t: result kind: expected %0d, actual %0d", $time, want.kind, user);
        mismatches++;
      end
      if (data[31:0] !== want.coord) begin
        $display("%0t: coordinate: expected %h, actual %h", $time, want.coord, data[31:0]);
        mismatches++;
      end
      if (data[63:32] !== want.distance) begin
        $display("%0t: distance: expected %h, actual %h", $time, want.distance, data[63:32]);
        mismatches++;
      end
      if (data[64] !== want.flag) begin
        $display("%0t: equal flag: expected %b, actual %b", $time, want.flag, data[64]);
        mismatches++;
      end
      if (data[71:65] !== 7'd0) begin
        $display("%0t: tdata padding: expected %h, actual %h", $time, 7'd0, data[71:65]);
        mismatches++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [wadi_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [1:0]                       in_tuser;
  logic                             in_tlast;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [wadi_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]                       out_tuser;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic                             cfg_index;
  logic [15:0]                      cfg_data;

  metric_scoreboard sb;

  // Idle rates in percent. The sender rate belongs to the main process; the receiver rate
  // and the stall request are handed to the receiver process with nonblocking writes.
  int send_idle_pct = 0;
  int recv_idle_pct;
  int hold_asks;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int beats_sent = 0;
  int settings_used = 0;

  wrapped_axis_distance_interpolate_core #(.AXES(8)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  // Result side. Everything is read right after the edge, so the values seen are the ones
  // the unit sampled. A requested stall holds tready low for a long stretch so the output
  // register fills and the unit backs up into its input.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tuser);
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_asks) begin
      hold_served = hold_asks;
      hold_left = PRESSURE_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any beat on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results still outstanding", $time,
                 quiet_cycles, sb.pending_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic axis_beat_t make_beat(wadi_pkg::wadi_func_t f, int ax, longint a,
                                           longint b, int frac, logic last);
    axis_beat_t beat;
    beat.func = f;
    beat.axis = ax[wadi_pkg::AXIS_W-1:0];
    beat.a    = a[wadi_pkg::VALUE_W-1:0];
    beat.b    = b[wadi_pkg::VALUE_W-1:0];
    beat.frac = frac[wadi_pkg::FRAC_W-1:0];
    beat.last = last;
    return beat;
  endfunction

  // Offers one beat after a random number of idle cycles and returns at the edge that took
  // it. tvalid stays high into the next call, which either changes the data or idles.
  task automatic send_beat(axis_beat_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, beat.frac, beat.b, beat.a, beat.axis};
    in_tuser  <= beat.func;
    in_tlast  <= beat.last;
    do @(posedge clk); while (!in_tready);
    sb.take_input(beat);
    beats_sent++;
  endtask

  // Leaves cfg_valid high so that writes can follow back to back; the caller closes the
  // channel after its last write.
  task automatic write_reg_port(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Waits for every predicted result, then lets any beat that gives no result finish too.
  task automatic drain_unit();
    in_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Coordinates lean toward the axis bounds and the extremes, where folding and saturation
  // happen; the rest are uniform over the whole field or between the axis bounds.
  function automatic longint pick_coord(int ax);
    longint lo, hi, span;
    int sel;
    lo   = sb.axis_low[ax];
    hi   = sb.axis_high[ax];
    span = hi - lo;
    sel  = $urandom_range(9);
    if (sel == 0) return Q_MIN;
    if (sel == 1) return Q_MAX;
    if (sel <= 3 || span <= 0) return longint'(int'($urandom));
    if (sel == 4) return ($urandom_range(1) ? hi : lo) + longint'($urandom_range(4)) - 2;
    return lo + (longint'($urandom) % (span + 1));
  endfunction

  function automatic int pick_fraction();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(131071, 65537);
      3:       return 32768;
      default: return $urandom_range(65536);
    endcase
  endfunction

  task automatic send_random_load(int ax);
    longint lo, hi;
    case ($urandom_range(5))
      0: begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      1: begin
        // Any order, including bounds given high-first.
        lo = int'($urandom);
        hi = int'($urandom);
      end
      default: begin
        lo = longint'(int'($urandom)) >>> $urandom_range(16);
        hi = lo + longint'($urandom >> $urandom_range(31));
        if (hi > Q_MAX) hi = Q_MAX;
      end
    endcase
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, ax, lo, hi, pick_fraction(), $urandom_range(1)));
  endtask

  task automatic run_random_phase();
    int sent;
    int len;
    int ax;
    wadi_pkg::wadi_func_t f;
    sent = 0;
    while (sent < BEATS_PER_PHASE) begin
      case ($urandom_range(19))
        0: begin
          send_random_load($urandom_range(7));
          sent++;
        end
        1, 2: begin
          // Out-of-order axis with a random end marker; partial vectors carry on.
          ax = $urandom_range(7);
          f  = wadi_pkg::wadi_func_t'($urandom_range(3, 1));
          send_beat(make_beat(f, ax, pick_coord(ax), pick_coord(ax), pick_fraction(),
                              $urandom_range(1)));
          sent++;
        end
        default: begin
          // A well-formed vector: axes in order from zero, tlast on the final one.
          f   = wadi_pkg::wadi_func_t'($urandom_range(3, 1));
          len = $urandom_range(8, 1);
          for (int k = 0; k < len; k++) begin
            send_beat(make_beat(f, k, pick_coord(k), pick_coord(k), pick_fraction(),
                                k == len - 1));
          end
          sent += len;
        end
      endcase
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= 1'b0;
    cfg_data  <= '0;
    hold_asks <= 0;
    recv_idle_pct <= 64;
    send_idle_pct = 38;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Axes 0, 1, 2 and 7 wrap: axis 0 spans the whole field, axis 1 is an
    // angle in degrees, axis 2 is symmetric and axis 7 has its bounds reversed so that its
    // span is negative. Tolerance is 1/256 of a unit.
    write_reg_port(wadi_pkg::CFG_WRAP_MASK, 16'h0087);
    write_reg_port(wadi_pkg::CFG_EQUAL_TOL, 16'h0100);
    cfg_valid <= 1'b0;
    settings_used++;
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 0, Q_MIN, Q_MAX, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 1, 0, 360 <<< 16, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 2, -(180 <<< 16), 180 <<< 16, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 3, -(1000 <<< 16), 1000 <<< 16, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 4, 0, 1 <<< 16, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 5, -1, 1, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 6, 0, 0, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_LOAD, 7, Q_MAX, Q_MIN, 0, 1'b1));

    // Distance: a full-span wrap that folds to zero, a negative span whose fold exceeds
    // 32 bits, then a non-wrapping extreme difference, which together saturate the sum.
    send_beat(make_beat(wadi_pkg::FUNC_DIST, 0, Q_MIN, Q_MAX, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_DIST, 7, Q_MAX, Q_MIN, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_DIST, 3, Q_MIN, Q_MAX, 0, 1'b1));
    // Short way round the angle axis, and a zero distance.
    send_beat(make_beat(wadi_pkg::FUNC_DIST, 1, 10 <<< 16, 350 <<< 16, 0, 1'b1));
    send_beat(make_beat(wadi_pkg::FUNC_DIST, 6, 0, 0, 0, 1'b1));

    // Equality: opposite ends of a wrapped axis match, a difference right at the tolerance
    // matches, one just past it does not.
    send_beat(make_beat(wadi_pkg::FUNC_EQUAL, 1, 0, 360 <<< 16, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_EQUAL, 4, 100, 356, 0, 1'b1));
    send_beat(make_beat(wadi_pkg::FUNC_EQUAL, 2, -(180 <<< 16), 180 <<< 16, 0, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_EQUAL, 3, 0, 257, 0, 1'b1));

    // Interpolation: folds in both directions, a result landing on the bound, t past one,
    // rounding ties of either sign, and saturation at the field limits.
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 1, 350 <<< 16, 10 <<< 16, 32768, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 1, 10 <<< 16, 350 <<< 16, 65536, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 3, Q_MIN, Q_MAX, 65536, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 3, Q_MAX, Q_MIN, 131071, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 5, 0, 1, 32768, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 5, 0, -1, 32768, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 0, Q_MAX, Q_MIN, 1, 1'b0));
    send_beat(make_beat(wadi_pkg::FUNC_INTERP, 7, 0, 12345, 0, 1'b1));
    drain_unit();

    // Random phases. Each starts from an idle unit with a new register setting; the first
    // two idle the sender lightly and the receiver heavily, the next two the reverse, and
    // the last two not at all. The second phase opens with a long output stall.
    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: begin
          write_reg_port(wadi_pkg::CFG_WRAP_MASK, 16'h0000);
          write_reg_port(wadi_pkg::CFG_EQUAL_TOL, 16'h0000);
        end
        2: begin
          write_reg_port(wadi_pkg::CFG_WRAP_MASK, 16'h00FF);
          write_reg_port(wadi_pkg::CFG_EQUAL_TOL, 16'hFFFF);
        end
        4: begin
          write_reg_port(wadi_pkg::CFG_WRAP_MASK, 16'h00FF);
          write_reg_port(wadi_pkg::CFG_EQUAL_TOL, 16'h0000);
        end
        5: begin
          write_reg_port(wadi_pkg::CFG_WRAP_MASK, 16'h0000);
          write_reg_port(wadi_pkg::CFG_EQUAL_TOL, 16'hFFFF);
        end
        default: begin
          write_reg_port(wadi_pkg::CFG_WRAP_MASK, 16'($urandom_range(255)));
          write_reg_port(wadi_pkg::CFG_EQUAL_TOL, 16'($urandom_range(65535)));
        end
      endcase
      cfg_valid <= 1'b0;
      settings_used++;
      if (p <= 2) begin
        send_idle_pct = 38;
        recv_idle_pct <= 64;
      end else if (p <= 4) begin
        send_idle_pct = 64;
        recv_idle_pct <= 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (p == 2) hold_asks <= hold_asks + 1;
      run_random_phase();
      drain_unit();
    end

    $display("Sent %0d input beats under %0d register settings, with idling on either side,",
             beats_sent, settings_used);
    $display("none at all and one long output stall; checked %0d coordinates, %0d distances, %s",
             sb.coords_seen, sb.dists_seen, $sformatf("%0d flags.", sb.flags_seen));
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/wadi_pkg.sv
rtl/core/wadi_ram.sv
rtl/core/wadi_isqrt.sv
rtl/core/wrapped_axis_distance_interpolate_core.sv
rtl/core/wadi_checker.sv
verif/wrapped_axis_distance_interpolate_core_test.sv
